@@ hdl/sssv_pkg.sv @@
// ----------------------------------------------------------------------------
// sssv_pkg
// Shared types, constants and the exponent lookup for the swept square voices.
// ----------------------------------------------------------------------------
package sssv_pkg;

  localparam int unsigned VoiceCountDef = 6;
  localparam int unsigned StepW         = 20;
  localparam int unsigned DurW          = 16;
  localparam int unsigned PitchW        = 16;
  localparam int unsigned PhaseW        = 32;
  localparam int unsigned SampleW       = 19;
  localparam int unsigned LutW          = 17;

  localparam logic [StepW-1:0] StepReset = 20'd89478;
  localparam logic [63:0]      Ln2Q32    = 64'd2977044472;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_DIV,
    ST_PITCH,
    ST_SCALE,
    ST_UPDATE,
    ST_OUT
  } state_e;

  // one voice word in the state memory
  typedef struct packed {
    logic [DurW-1:0]   vtime;
    logic [DurW-1:0]   vlength;
    logic [PhaseW-1:0] vphase;
    logic [PitchW-1:0] pitch_from;
    logic [PitchW-1:0] pitch_to;
  } voice_t;

  typedef logic [LutW-1:0] exp_lut_t [256];

  // 2^(k/256) in Q16, truncated Q32 power series, rounded
  function automatic logic [LutW-1:0] pow2_frac(input logic [7:0] k);
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] rnd;
    x    = ({56'd0, k} * Ln2Q32) >> 8;
    term = 64'd1 << 32;
    sum  = term;
    term = ((term * x) >> 32) / 64'd1;  sum = sum + term;
    term = ((term * x) >> 32) / 64'd2;  sum = sum + term;
    term = ((term * x) >> 32) / 64'd3;  sum = sum + term;
    term = ((term * x) >> 32) / 64'd4;  sum = sum + term;
    term = ((term * x) >> 32) / 64'd5;  sum = sum + term;
    term = ((term * x) >> 32) / 64'd6;  sum = sum + term;
    term = ((term * x) >> 32) / 64'd7;  sum = sum + term;
    term = ((term * x) >> 32) / 64'd8;  sum = sum + term;
    term = ((term * x) >> 32) / 64'd9;  sum = sum + term;
    term = ((term * x) >> 32) / 64'd10; sum = sum + term;
    term = ((term * x) >> 32) / 64'd11; sum = sum + term;
    term = ((term * x) >> 32) / 64'd12; sum = sum + term;
    term = ((term * x) >> 32) / 64'd13; sum = sum + term;
    term = ((term * x) >> 32) / 64'd14; sum = sum + term;
    term = ((term * x) >> 32) / 64'd15; sum = sum + term;
    term = ((term * x) >> 32) / 64'd16; sum = sum + term;
    term = ((term * x) >> 32) / 64'd17; sum = sum + term;
    term = ((term * x) >> 32) / 64'd18; sum = sum + term;
    term = ((term * x) >> 32) / 64'd19; sum = sum + term;
    term = ((term * x) >> 32) / 64'd20; sum = sum + term;
    rnd  = (sum + (64'd1 << 15)) >> 16;
    return rnd[LutW-1:0];
  endfunction

  function automatic exp_lut_t build_exp_lut();
    exp_lut_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = pow2_frac(8'(i));
    end
    return t;
  endfunction

  localparam exp_lut_t ExpLut = build_exp_lut();

endpackage

@@ hdl/swept_square_voice_synth.sv @@
// ----------------------------------------------------------------------------
// swept_square_voice_synth
// Bank of square-wave voices with log-pitch sweep and quadratic decay.
// Trigger word: taken and written in the idle state. Tick word: accepted, then per
//   voice a read and a check if idle, plus a wait on the shared divider and the
//   pitch, scale and update steps if active, then the result is loaded to the
//   output, which an output stall can hold. One word in work at a time.
// Reset: voices off, slot pointer zero, step register at its default; the
//   voice memory holds no reset value and is written by a trigger before use.
// ----------------------------------------------------------------------------
module swept_square_voice_synth #(
  parameter int unsigned VOICE_COUNT = sssv_pkg::VoiceCountDef,
  localparam int unsigned VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sssv_pkg::StepW-1:0]    cfg_phase_step_per_hz_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          cmd_i,
  input  logic [sssv_pkg::DurW-1:0]     duration_samples_i,
  input  logic [sssv_pkg::PitchW-1:0]   start_pitch_i,
  input  logic [sssv_pkg::PitchW-1:0]   end_pitch_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [sssv_pkg::SampleW-1:0] sample_o
);

  localparam int unsigned SW = sssv_pkg::SampleW;
  localparam logic [VW-1:0] LastVoice = VW'(VOICE_COUNT - 1);

  sssv_pkg::state_e state_q, state_d;

  logic [sssv_pkg::StepW-1:0]  step_q;
  logic [VOICE_COUNT-1:0]      on_q, on_d;
  logic [VW-1:0]               slot_q, slot_d;
  logic [VW-1:0]               vidx_q, vidx_d;
  logic [SW-1:0]               acc_q, acc_d;
  logic                        out_valid_q, out_valid_d;
  logic [SW-1:0]               sample_q, sample_d;
  logic [sssv_pkg::PitchW-1:0] pitch_q, pitch_d;
  logic [36:0]                 scaled_q, scaled_d;

  sssv_pkg::voice_t rd_word, wr_word;
  logic             ram_we, ram_re;
  logic [VW-1:0]    ram_waddr;

  logic             div_start, div_done;
  logic [15:0]      progress;

  logic               in_acc;
  logic signed [16:0] pdiff;
  logic signed [33:0] pprod;
  logic [51:0]        shifted;
  logic [31:0]        new_phase;
  logic [16:0]        env;
  logic [33:0]        env_sq;
  logic [16:0]        amp;

  assign in_acc      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == sssv_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;

  sssv_ram #(
    .Width($bits(sssv_pkg::voice_t)),
    .Depth(VOICE_COUNT)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(wr_word),
    .re_i   (ram_re),
    .raddr_i(vidx_q),
    .rdata_o(rd_word)
  );

  sssv_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (rd_word.vtime),
    .den_i  (rd_word.vlength),
    .done_o (div_done),
    .quo_o  (progress)
  );

  // datapath terms
  always_comb begin
    pdiff     = $signed({1'b0, rd_word.pitch_to}) - $signed({1'b0, rd_word.pitch_from});
    pprod     = pdiff * $signed({1'b0, progress});
    shifted   = {15'd0, scaled_q} << pitch_q[15:12];
    new_phase = rd_word.vphase + shifted[47:16];
    env       = 17'h10000 - {1'b0, progress};
    env_sq    = env * env;
    amp       = env_sq[33:17];
  end

  always_comb begin
    state_d     = state_q;
    on_d        = on_q;
    slot_d      = slot_q;
    vidx_d      = vidx_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q;
    sample_d    = sample_q;
    pitch_d     = pitch_q;
    scaled_d    = scaled_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = vidx_q;
    wr_word     = rd_word;
    div_start   = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      sssv_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (cmd_i) begin
            ram_we             = 1'b1;
            ram_waddr          = slot_q;
            wr_word.vtime      = '0;
            wr_word.vphase     = '0;
            wr_word.vlength    = duration_samples_i;
            wr_word.pitch_from = start_pitch_i;
            wr_word.pitch_to   = end_pitch_i;
            on_d[slot_q]       = 1'b1;
            slot_d             = (slot_q == LastVoice) ? '0 : slot_q + VW'(1);
          end else begin
            vidx_d  = '0;
            acc_d   = '0;
            state_d = sssv_pkg::ST_READ;
          end
        end
      end
      sssv_pkg::ST_READ: begin
        ram_re  = 1'b1;
        state_d = sssv_pkg::ST_CHECK;
      end
      sssv_pkg::ST_CHECK: begin
        if (on_q[vidx_q] && (rd_word.vtime < rd_word.vlength)) begin
          div_start = 1'b1;
          state_d   = sssv_pkg::ST_DIV;
        end else begin
          on_d[vidx_q] = 1'b0;
          if (vidx_q == LastVoice) begin
            state_d = sssv_pkg::ST_OUT;
          end else begin
            vidx_d  = vidx_q + VW'(1);
            state_d = sssv_pkg::ST_READ;
          end
        end
      end
      sssv_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = sssv_pkg::ST_PITCH;
        end
      end
      sssv_pkg::ST_PITCH: begin
        // from + floor((to - from) * progress / 2^16)
        pitch_d = rd_word.pitch_from + pprod[31:16];
        state_d = sssv_pkg::ST_SCALE;
      end
      sssv_pkg::ST_SCALE: begin
        scaled_d = sssv_pkg::ExpLut[pitch_q[11:4]] * step_q;
        state_d  = sssv_pkg::ST_UPDATE;
      end
      sssv_pkg::ST_UPDATE: begin
        ram_we         = 1'b1;
        wr_word.vtime  = rd_word.vtime + 16'd1;
        wr_word.vphase = new_phase;
        acc_d = new_phase[31] ? (acc_q - {2'b00, amp}) : (acc_q + {2'b00, amp});
        if (vidx_q == LastVoice) begin
          state_d = sssv_pkg::ST_OUT;
        end else begin
          vidx_d  = vidx_q + VW'(1);
          state_d = sssv_pkg::ST_READ;
        end
      end
      sssv_pkg::ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          sample_d    = acc_q;
          state_d     = sssv_pkg::ST_IDLE;
        end
      end
      default: state_d = sssv_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sssv_pkg::ST_IDLE;
      step_q      <= sssv_pkg::StepReset;
      on_q        <= '0;
      slot_q      <= '0;
      vidx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      on_q        <= on_d;
      slot_q      <= slot_d;
      vidx_q      <= vidx_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        step_q <= cfg_phase_step_per_hz_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    sample_q <= sample_d;
    pitch_q  <= pitch_d;
    scaled_q <= scaled_d;
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = $signed(sample_q);

`ifndef NO_ASSERTIONS
  a_trigger_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && cmd_i) |=> on_q[$past(slot_q)])
    else $error("triggered voice not armed");

  a_out_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == sssv_pkg::ST_OUT))
    else $error("result loaded outside the output step");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (slot_q <= LastVoice) && (vidx_q <= LastVoice))
    else $error("voice index out of range");

  a_pitch_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sssv_pkg::ST_PITCH) |-> $past(div_done))
    else $error("pitch step without a finished divide");
`endif

endmodule

@@ hdl/sssv_ram.sv @@
// ----------------------------------------------------------------------------
// sssv_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sssv_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/sssv_div.sv @@
// ----------------------------------------------------------------------------
// sssv_div
// Restoring divider, one quotient bit per cycle: (num << 16) / den, num < den.
// ----------------------------------------------------------------------------
module sssv_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [sssv_pkg::DurW-1:0] num_i,
  input  logic [sssv_pkg::DurW-1:0] den_i,
  output logic                     done_o,
  output logic [sssv_pkg::DurW-1:0] quo_o
);

  localparam int unsigned W = sssv_pkg::DurW;

  logic         busy_q, done_q;
  logic [3:0]   cnt_q;
  logic [W:0]   rem_q;
  logic [W-1:0] quo_q;
  logic [W-1:0] den_q;
  logic [W:0]   trial;
  logic         ge;

  assign trial = {rem_q[W-1:0], 1'b0};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 4'd1;
      if (cnt_q == 4'd15) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, num_i};
      quo_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? (trial - {1'b0, den_q}) : trial;
      quo_q <= {quo_q[W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
